// ===== rtl/bsa_pkg.sv =====
// bsa_pkg: shared constants for the bitmap slot allocator
// item kind codes, field widths and the default slot count
// no dependencies
package bsa_pkg;

  localparam int SLOT_COUNT_DEF = 32;
  localparam int WORD_W         = 32;
  localparam int COUNT_W        = 6;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

endpackage

// ===== rtl/bitmap_slot_allocator.sv =====
// bitmap_slot_allocator: free slot map with allocate and free commands
// depends on bsa_pkg
//
// Usage: the input word (in_kind, in_count, in_release_mask) is taken at a
// rising edge where start is high and busy is low. Each word produces one
// result word on out_granted_mask, out_granted and out_free_map, shown for
// exactly one cycle while out_valid is high; the receiver cannot stall it.
// A free word or a failing allocate (count zero or above SLOT_COUNT) shows
// its result in the cycle after it is taken, and busy stays low, so such
// words may follow back to back. A legal allocate of n slots walks the map
// with one shared subtract unit that strips the lowest free slot each cycle
// while busy is high; the result word follows once all n slots are taken,
// or earlier, as a failed grant, when the map runs out of free slots.
// The next word may be started while a result is on the output.
// Reset (synchronous, rst_n low) marks every slot free and drops out_valid.
// Map bits above bit 31 are tracked but not shown on the output words.
module bitmap_slot_allocator
  import bsa_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_kind,
  input  logic [COUNT_W-1:0]  in_count,
  input  logic [WORD_W-1:0]   in_release_mask,
  output logic                out_valid,
  output logic [WORD_W-1:0]   out_granted_mask,
  output logic                out_granted,
  output logic [WORD_W-1:0]   out_free_map
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t                 state_r, state_nxt;
  logic [SLOT_COUNT-1:0]  free_r, free_nxt;
  logic [SLOT_COUNT-1:0]  rest_r, rest_nxt;
  logic [SLOT_COUNT-1:0]  grant_r, grant_nxt;
  logic [COUNT_W-1:0]     left_r, left_nxt;
  logic                   vld_r, vld_nxt;
  logic [WORD_W-1:0]      og_mask_r, og_mask_nxt;
  logic                   og_ok_r, og_ok_nxt;
  logic [WORD_W-1:0]      ofree_r, ofree_nxt;

  logic [SLOT_COUNT-1:0]     rest_dec;
  logic [SLOT_COUNT-1:0]     lowest;
  logic [SLOT_COUNT+WORD_W-1:0] rel_ext;
  logic [SLOT_COUNT-1:0]     rel;
  logic [SLOT_COUNT-1:0]     freed;
  logic                      count_ok;

  // shared unit: strip lowest set bit
  assign rest_dec = rest_r - SLOT_COUNT'(1);
  assign lowest   = rest_r & ~rest_dec;

  assign rel_ext  = {{SLOT_COUNT{1'b0}}, in_release_mask};
  assign rel      = rel_ext[SLOT_COUNT-1:0];
  assign freed    = free_r | rel;
  assign count_ok = (in_count != '0) && (32'(in_count) <= SLOT_COUNT);

  function automatic logic [WORD_W-1:0] to_word(input logic [SLOT_COUNT-1:0] m);
    logic [SLOT_COUNT+WORD_W-1:0] ext;
    ext = {{WORD_W{1'b0}}, m};
    return ext[WORD_W-1:0];
  endfunction

  always_comb begin
    state_nxt   = state_r;
    free_nxt    = free_r;
    rest_nxt    = rest_r;
    grant_nxt   = grant_r;
    left_nxt    = left_r;
    vld_nxt     = 1'b0;
    og_mask_nxt = og_mask_r;
    og_ok_nxt   = og_ok_r;
    ofree_nxt   = ofree_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_kind == KIND_FREE) begin
            free_nxt    = freed;
            vld_nxt     = 1'b1;
            og_mask_nxt = '0;
            og_ok_nxt   = 1'b0;
            ofree_nxt   = to_word(freed);
          end else if (!count_ok) begin
            vld_nxt     = 1'b1;
            og_mask_nxt = '0;
            og_ok_nxt   = 1'b0;
            ofree_nxt   = to_word(free_r);
          end else begin
            rest_nxt  = free_r;
            grant_nxt = '0;
            left_nxt  = in_count;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (left_r == '0) begin
          free_nxt    = rest_r;
          vld_nxt     = 1'b1;
          og_mask_nxt = to_word(grant_r);
          og_ok_nxt   = 1'b1;
          ofree_nxt   = to_word(rest_r);
          state_nxt   = ST_IDLE;
        end else if (rest_r == '0) begin
          // short of slots, map untouched
          vld_nxt     = 1'b1;
          og_mask_nxt = '0;
          og_ok_nxt   = 1'b0;
          ofree_nxt   = to_word(free_r);
          state_nxt   = ST_IDLE;
        end else begin
          rest_nxt  = rest_r & rest_dec;
          grant_nxt = grant_r | lowest;
          left_nxt  = left_r - COUNT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      free_r  <= '1;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      free_r  <= free_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rest_r    <= rest_nxt;
    grant_r   <= grant_nxt;
    left_r    <= left_nxt;
    og_mask_r <= og_mask_nxt;
    og_ok_r   <= og_ok_nxt;
    ofree_r   <= ofree_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = vld_r;
  assign out_granted_mask = og_mask_r;
  assign out_granted      = og_ok_r;
  assign out_free_map     = ofree_r;

endmodule

// ===== test/bitmap_slot_allocator_chk.sv =====
// bitmap_slot_allocator_chk: watches the command and result channels of the allocator,
// keeps its own free map, predicts each result word and compares it field by field
// depends on bsa_pkg
module bitmap_slot_allocator_chk
  import bsa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_kind,
  input  logic [COUNT_W-1:0] in_count,
  input  logic [WORD_W-1:0]  in_release_mask,
  input  logic               out_valid,
  input  logic [WORD_W-1:0]  out_granted_mask,
  input  logic               out_granted,
  input  logic [WORD_W-1:0]  out_free_map,
  output int                 fail_count,
  output int                 words_outstanding
);

  typedef struct packed {
    logic [WORD_W-1:0] grant_mask;
    logic              granted;
    logic [WORD_W-1:0] map;
  } slot_result_t;

  slot_result_t      result_q[$];
  logic [WORD_W-1:0] free_map_model;

  initial begin
    fail_count        = 0;
    words_outstanding = 0;
    free_map_model    = '1;
  end

  function automatic slot_result_t apply_word(input logic kind, input logic [COUNT_W-1:0] cnt,
                                              input logic [WORD_W-1:0] rel,
                                              input logic [WORD_W-1:0] map_in);
    slot_result_t      r;
    logic [WORD_W-1:0] rest;
    int                need;
    r     = '0;
    r.map = map_in;
    if (kind == KIND_FREE) begin
      r.map = map_in | rel;
    end else if (cnt >= 1 && cnt <= SLOT_COUNT_DEF) begin
      rest = map_in;
      need = cnt;
      // strip the lowest free slot once per slot asked for
      while (need > 0 && rest != '0) begin
        rest = rest & (rest - 1'b1);
        need--;
      end
      if (need == 0) begin
        r.grant_mask = map_in & ~rest;
        r.granted    = 1'b1;
        r.map        = rest;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    slot_result_t want;
    slot_result_t nxt;
    if (!rst_n) begin
      result_q.delete();
      free_map_model = '1;
      words_outstanding <= 0;
    end else begin
      if (out_valid) begin
        if (result_q.size() == 0) begin
          $error("result word with nothing outstanding: granted_mask %h free_map %h",
                 out_granted_mask, out_free_map);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (out_granted_mask !== want.grant_mask) begin
            $error("granted_mask: expected %h actual %h", want.grant_mask, out_granted_mask);
            fail_count++;
          end
          if (out_granted !== want.granted) begin
            $error("granted: expected %b actual %b", want.granted, out_granted);
            fail_count++;
          end
          if (out_free_map !== want.map) begin
            $error("free_map: expected %h actual %h", want.map, out_free_map);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        nxt = apply_word(in_kind, in_count, in_release_mask, free_map_model);
        free_map_model = nxt.map;
        result_q.push_back(nxt);
      end
      words_outstanding <= result_q.size();
    end
  end

endmodule

// ===== test/bitmap_slot_allocator_tb.sv =====
// bitmap_slot_allocator_tb: drives allocate and free words into the allocator,
// directed corner words first, then random traffic under several idle phases
// depends on bsa_pkg, bitmap_slot_allocator and bitmap_slot_allocator_chk
module bitmap_slot_allocator_tb;
  import bsa_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_kind = KIND_ALLOC;
  logic [COUNT_W-1:0] in_count = '0;
  logic [WORD_W-1:0]  in_release_mask = '0;
  logic               out_valid;
  logic [WORD_W-1:0]  out_granted_mask;
  logic               out_granted;
  logic [WORD_W-1:0]  out_free_map;
  int                 fail_count;
  int                 words_outstanding;
  int                 idle_pct = 0;

  bitmap_slot_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_count         (in_count),
    .in_release_mask  (in_release_mask),
    .out_valid        (out_valid),
    .out_granted_mask (out_granted_mask),
    .out_granted      (out_granted),
    .out_free_map     (out_free_map)
  );

  bitmap_slot_allocator_chk chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_count          (in_count),
    .in_release_mask   (in_release_mask),
    .out_valid         (out_valid),
    .out_granted_mask  (out_granted_mask),
    .out_granted       (out_granted),
    .out_free_map      (out_free_map),
    .fail_count        (fail_count),
    .words_outstanding (words_outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

  task automatic send_word(input logic kind, input logic [COUNT_W-1:0] cnt,
                           input logic [WORD_W-1:0] rel);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start           <= 1'b1;
    in_kind         <= kind;
    in_count        <= cnt;
    in_release_mask <= rel;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (words_outstanding != 0) @(posedge clk);
  endtask

  task automatic send_random_word();
    logic               kind;
    logic [COUNT_W-1:0] cnt;
    logic [WORD_W-1:0]  rel;
    int                 pick;
    kind = ($urandom_range(99) < 55) ? KIND_ALLOC : KIND_FREE;
    pick = $urandom_range(99);
    if (pick < 80) cnt = COUNT_W'($urandom_range(1, 6));
    else if (pick < 90) cnt = COUNT_W'($urandom_range(7, 32));
    else cnt = COUNT_W'($urandom_range(0, 63));
    pick = $urandom_range(99);
    if (pick < 60) rel = $urandom & $urandom;
    else if (pick < 80) rel = $urandom;
    else if (pick < 90) rel = 32'h1 << $urandom_range(31);
    else rel = ($urandom_range(1)) ? '1 : '0;
    send_word(kind, cnt, rel);
  endtask

  initial begin : stimulus
    int phase_idle[5];
    phase_idle = '{0, 67, 0, 17, 67};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(KIND_ALLOC, 6'd0, '0);
    send_word(KIND_ALLOC, 6'd33, '0);
    send_word(KIND_ALLOC, 6'd63, '1);
    send_word(KIND_ALLOC, 6'd1, '0);
    send_word(KIND_ALLOC, 6'd31, 32'h1234_5678);
    send_word(KIND_ALLOC, 6'd1, '0);
    send_word(KIND_FREE, 6'd0, '0);
    send_word(KIND_FREE, 6'd63, 32'h8000_0001);
    send_word(KIND_FREE, 6'd5, 32'h8000_0001);
    send_word(KIND_ALLOC, 6'd3, '0);
    send_word(KIND_ALLOC, 6'd2, '0);
    send_word(KIND_FREE, 6'd0, '1);
    send_word(KIND_ALLOC, 6'd32, '0);
    send_word(KIND_FREE, 6'd0, 32'hAAAA_AAAA);
    send_word(KIND_ALLOC, 6'd17, '0);
    send_word(KIND_ALLOC, 6'd16, '0);
    send_word(KIND_FREE, 6'd32, 32'h5555_5555);
    send_word(KIND_ALLOC, 6'd5, 32'hFFFF_0000);
    send_word(KIND_FREE, 6'd0, 32'hF0F0_0F0F);
    send_word(KIND_ALLOC, 6'd32, '0);
    send_word(KIND_FREE, 6'd1, '1);
    drain_results();

    for (int ph = 0; ph < 5; ph++) begin
      idle_pct = phase_idle[ph];
      for (int i = 0; i < 90; i++) begin
        send_random_word();
        if (i == 45 && ph == 1) drain_results();
      end
      drain_results();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0 && words_outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
